FILE: hdl/ffha_pkg.sv
package ffha_pkg;

    // Width of the value taken by the constant divider: a byte count plus rounding.
    localparam int DIV_XW = 15;

    localparam int REQ_W  = 14;
    localparam int OFF_W  = 13;
    localparam int HB_W   = 14;
    localparam int STAT_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd3;

    localparam logic [HB_W-1:0] HEAP_BYTES_RESET = 14'd8192;

    typedef struct packed {
        logic              valid;
        logic [DIV_XW-1:0] quot;
        logic              exact;
    } t_div_res;

endpackage

FILE: hdl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ffha_div.sv
module ffha_div #(
    parameter int WORD_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ffha_pkg::DIV_XW-1:0] i_x,
    output ffha_pkg::t_div_res          o_res
);

    // Quotient by a constant: multiply by a truncated reciprocal, then one
    // correction step. The estimate is low by at most one.
    localparam int SH    = 16;
    localparam int RECIP = (1 << SH) / WORD_BYTES;
    localparam int PW    = ffha_pkg::DIV_XW + SH;
    localparam int RW    = 20;

    logic                        r_v1;
    logic [ffha_pkg::DIV_XW-1:0] r_x;
    logic [PW-1:0]               r_prod;
    ffha_pkg::t_div_res          r_res;

    logic [ffha_pkg::DIV_XW-1:0] q0;
    logic [RW-1:0]               back;
    logic [RW-1:0]               rem0;
    logic                        corr;

    assign q0   = r_prod[PW-1:SH];
    assign back = RW'(q0) * RW'(WORD_BYTES);
    assign rem0 = RW'(r_x) - back;
    assign corr = (rem0 >= RW'(WORD_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_v1        <= i_start;
            r_res.valid <= r_v1;
        end
        r_x        <= i_x;
        r_prod     <= PW'(i_x) * PW'(RECIP);
        r_res.quot <= corr ? q0 + 1'b1 : q0;
        r_res.exact <= corr ? (rem0 == RW'(WORD_BYTES)) : (rem0 == '0);
    end

    assign o_res = r_res;

endmodule

FILE: hdl/first_fit_heap_allocator.sv
// Channel   Direction  Accept condition             Contents
// s         in         i_s_tvalid & o_s_tready      tuser: cmd; tdata: request_bytes, payload_offset
// m         out        o_m_tvalid & i_m_tready      tdata: status, granted_offset, granted_bytes
// cfg       in         i_cfg_valid & o_cfg_ready    heap_bytes
//
// One request is worked on at a time; the header memory port sets the pace.
// An allocate reads and evaluates the headers one after another until one fits;
// a free reads its own header and the next. Both first pass the constant divider.
// After reset and after a heap_bytes write, which is taken only while idle, the heap
// is formatted by a pass over all HEAP_WORDS entries, readies low.
// A new request is taken while the previous result still waits in the output
// register; a request only stalls at its end until that register is free.
module first_fit_heap_allocator #(
    parameter int HEAP_WORDS = 1024,
    parameter int WORD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,   // [0] cmd
    input  logic [31:0] i_s_tdata,   // [13:0] request_bytes, [26:14] payload_offset
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [1:0] status, [14:2] granted_offset, [28:15] granted_bytes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_data
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int LW = AW + 1;
    localparam int HW = AW + 1;
    localparam int IW = AW + 2;
    localparam int XW = ffha_pkg::DIV_XW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FMT_DIV  = 4'd1;
    localparam logic [3:0] S_FMT_WAIT = 4'd2;
    localparam logic [3:0] S_CLEAR    = 4'd3;
    localparam logic [3:0] S_DIV_GO   = 4'd4;
    localparam logic [3:0] S_DIV_WAIT = 4'd5;
    localparam logic [3:0] S_A_RD     = 4'd6;
    localparam logic [3:0] S_A_EV     = 4'd7;
    localparam logic [3:0] S_A_SPLIT  = 4'd8;
    localparam logic [3:0] S_F_RD1    = 4'd9;
    localparam logic [3:0] S_F_EV1    = 4'd10;
    localparam logic [3:0] S_F_RD2    = 4'd11;
    localparam logic [3:0] S_F_EV2    = 4'd12;
    localparam logic [3:0] S_F_CLR    = 4'd13;
    localparam logic [3:0] S_PUSH     = 4'd14;

    logic [3:0]                    r_st, n_st;
    logic [ffha_pkg::HB_W-1:0]     r_heap_bytes;
    logic [LW-1:0]                 r_heap_len, n_heap_len;
    logic [LW-1:0]                 r_clr, n_clr;
    logic                          r_cmd, n_cmd;
    logic [ffha_pkg::REQ_W-1:0]    r_req, n_req;
    logic [ffha_pkg::OFF_W-1:0]    r_off, n_off;
    logic [XW-1:0]                 r_rw, n_rw;
    logic [IW-1:0]                 r_i, n_i;
    logic [IW-1:0]                 r_nx, n_nx;
    logic [HW-1:0]                 r_h, n_h;
    logic [ffha_pkg::STAT_W-1:0]   r_res_status, n_res_status;
    logic [ffha_pkg::OFF_W-1:0]    r_res_off, n_res_off;
    logic [ffha_pkg::REQ_W-1:0]    r_res_bytes, n_res_bytes;
    logic                          r_out_valid;
    logic [31:0]                   r_out_data;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [HW-1:0]                 wdata;
    logic [AW-1:0]                 raddr;
    logic [HW-1:0]                 rd;
    logic                          h_neg, h_zero, h_pos;
    logic [HW-1:0]                 h_mag;
    logic                          div_start;
    logic [XW-1:0]                 div_x;
    ffha_pkg::t_div_res            div_res;
    logic                          s_acc;
    logic                          cfg_acc;
    logic                          push_load;

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (HEAP_WORDS)
    ) u_hdr (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    ffha_div #(
        .WORD_BYTES (WORD_BYTES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (div_x),
        .o_res   (div_res)
    );

    // A heap_bytes write takes precedence over a request offered in the same cycle.
    assign o_s_tready  = (r_st == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_st == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign push_load   = (r_st == S_PUSH) && (!r_out_valid || i_m_tready);

    assign div_start = (r_st == S_FMT_DIV) || (r_st == S_DIV_GO);
    assign div_x     = (r_st == S_FMT_DIV) ? XW'(r_heap_bytes) :
                       (r_cmd == ffha_pkg::CMD_ALLOC) ? XW'(r_req) + XW'(WORD_BYTES - 1) :
                       XW'(r_off);

    assign raddr  = (r_st == S_F_RD2) ? r_nx[AW-1:0] : r_i[AW-1:0];
    assign h_neg  = rd[HW-1];
    assign h_zero = (rd == '0);
    assign h_pos  = !h_neg && !h_zero;
    assign h_mag  = h_neg ? HW'(0) - rd : rd;

    always_comb begin
        logic [31:0] q32;
        logic [31:0] nh32;
        logic [31:0] nx32;

        n_st         = r_st;
        n_heap_len   = r_heap_len;
        n_clr        = r_clr;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_off        = r_off;
        n_rw         = r_rw;
        n_i          = r_i;
        n_nx         = r_nx;
        n_h          = r_h;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_bytes  = r_res_bytes;
        we           = 1'b0;
        waddr        = r_i[AW-1:0];
        wdata        = '0;
        q32          = 32'(div_res.quot);
        nh32         = 32'(r_i) + 32'd1 + 32'(r_rw);
        nx32         = 32'(r_i) + 32'd1 + 32'(h_mag);

        unique case (r_st)
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd        = i_s_tuser;
                    n_req        = i_s_tdata[13:0];
                    n_off        = i_s_tdata[26:14];
                    n_res_status = ffha_pkg::ST_DONE;
                    n_res_off    = '0;
                    n_res_bytes  = '0;
                    if (i_s_tuser == ffha_pkg::CMD_ALLOC && i_s_tdata[13:0] == '0) begin
                        n_res_status = ffha_pkg::ST_ZERO;
                        n_st         = S_PUSH;
                    end else begin
                        n_st = S_DIV_GO;
                    end
                end
            end
            S_FMT_DIV: begin
                n_st = S_FMT_WAIT;
            end
            S_FMT_WAIT: begin
                if (div_res.valid) begin
                    if (q32 > 32'(HEAP_WORDS)) begin
                        n_heap_len = LW'(HEAP_WORDS);
                    end else if (q32 < 32'd4) begin
                        n_heap_len = '0;
                    end else begin
                        n_heap_len = LW'(div_res.quot);
                    end
                    n_clr = '0;
                    n_st  = S_CLEAR;
                end
            end
            S_CLEAR: begin
                // Zero every word; word 1 receives the single free block unless the heap length is zero.
                we    = 1'b1;
                waddr = r_clr[AW-1:0];
                if (r_clr == LW'(1) && r_heap_len != '0) begin
                    wdata = HW'(r_heap_len - LW'(3));
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == LW'(HEAP_WORDS - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_DIV_GO: begin
                n_st = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_res.valid) begin
                    if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                        n_rw = div_res.quot;
                        n_i  = IW'(1);
                        if (r_heap_len == '0 || q32 > 32'(r_heap_len)) begin
                            n_res_status = ffha_pkg::ST_NOFIT;
                            n_st         = S_PUSH;
                        end else begin
                            n_st = S_A_RD;
                        end
                    end else begin
                        n_i = IW'(div_res.quot - 1'b1);
                        if (!div_res.exact || q32 < 32'd2 || r_heap_len == '0 ||
                            q32 - 32'd1 >= 32'(r_heap_len) - 32'd1) begin
                            n_res_status = ffha_pkg::ST_BADFREE;
                            n_st         = S_PUSH;
                        end else begin
                            n_st = S_F_RD1;
                        end
                    end
                end
            end
            S_A_RD: begin
                if (32'(r_i) < 32'(r_heap_len) - 32'd1) begin
                    n_st = S_A_EV;
                end else begin
                    n_res_status = ffha_pkg::ST_NOFIT;
                    n_st         = S_PUSH;
                end
            end
            S_A_EV: begin
                if (h_zero) begin
                    n_res_status = ffha_pkg::ST_NOFIT;
                    n_st         = S_PUSH;
                end else if (h_pos && 32'(r_rw) + 32'd1 < 32'(h_mag)) begin
                    we           = 1'b1;
                    wdata        = HW'(0) - HW'(r_rw);
                    n_h          = h_mag;
                    n_res_off    = ffha_pkg::OFF_W'((32'(r_i) + 32'd1) * 32'(WORD_BYTES));
                    n_res_bytes  = ffha_pkg::REQ_W'(32'(r_rw) * 32'(WORD_BYTES));
                    n_st         = S_A_SPLIT;
                end else if (h_pos && 32'(r_rw) <= 32'(h_mag)) begin
                    we           = 1'b1;
                    wdata        = HW'(0) - h_mag;
                    n_res_off    = ffha_pkg::OFF_W'((32'(r_i) + 32'd1) * 32'(WORD_BYTES));
                    n_res_bytes  = ffha_pkg::REQ_W'(32'(h_mag) * 32'(WORD_BYTES));
                    n_st         = S_PUSH;
                end else begin
                    n_i  = IW'(nx32);
                    n_st = S_A_RD;
                end
            end
            S_A_SPLIT: begin
                // Header of the remainder block right after the granted payload.
                if (nh32 < 32'(HEAP_WORDS)) begin
                    we    = 1'b1;
                    waddr = nh32[AW-1:0];
                    wdata = r_h - HW'(1) - HW'(r_rw);
                end
                n_st = S_PUSH;
            end
            S_F_RD1: begin
                n_st = S_F_EV1;
            end
            S_F_EV1: begin
                if (!h_neg) begin
                    n_res_status = ffha_pkg::ST_BADFREE;
                    n_st         = S_PUSH;
                end else begin
                    n_h  = h_mag;
                    n_nx = IW'(nx32);
                    if (nx32 < 32'(r_heap_len)) begin
                        n_st = S_F_RD2;
                    end else begin
                        we    = 1'b1;
                        wdata = h_mag;
                        n_st  = S_PUSH;
                    end
                end
            end
            S_F_RD2: begin
                n_st = S_F_EV2;
            end
            S_F_EV2: begin
                we = 1'b1;
                if (h_pos) begin
                    wdata = r_h + HW'(1) + rd;
                    n_st  = S_F_CLR;
                end else begin
                    wdata = r_h;
                    n_st  = S_PUSH;
                end
            end
            S_F_CLR: begin
                // The absorbed block's header is no longer live.
                we    = 1'b1;
                waddr = r_nx[AW-1:0];
                wdata = '0;
                n_st  = S_PUSH;
            end
            S_PUSH: begin
                if (push_load) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        if (cfg_acc) begin
            n_st = S_FMT_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_FMT_DIV;
            r_heap_bytes <= ffha_pkg::HEAP_BYTES_RESET;
            r_heap_len   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_heap_len <= n_heap_len;
            if (cfg_acc) begin
                r_heap_bytes <= i_cfg_data;
            end
            if (push_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_clr        <= n_clr;
        r_cmd        <= n_cmd;
        r_req        <= n_req;
        r_off        <= n_off;
        r_rw         <= n_rw;
        r_i          <= n_i;
        r_nx         <= n_nx;
        r_h          <= n_h;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_bytes  <= n_res_bytes;
        if (push_load) begin
            r_out_data <= {3'b000, r_res_bytes, r_res_off, r_res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_div_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.valid |-> (r_st == S_DIV_WAIT || r_st == S_FMT_WAIT || r_st == S_FMT_DIV))
        else $error("divider result arrived outside a wait state");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_st == S_CLEAR || r_st == S_A_EV || r_st == S_A_SPLIT ||
                r_st == S_F_EV1 || r_st == S_F_EV2 || r_st == S_F_CLR))
        else $error("header memory written in a state that does not modify");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != ffha_pkg::ST_DONE) |-> (o_m_tdata[28:2] == '0))
        else $error("failed request carries a grant");

    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_A_RD || r_st == S_A_EV) |-> (r_i != '0))
        else $error("header walk at the size word");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_cfg_valid) |=> !o_s_tready)
        else $error("second request accepted while the first is in progress");

endmodule
